[hdl/sfc_pkg.sv]
package sfc_pkg;

   localparam int unsigned CoordW  = 20;
   localparam int unsigned RadiusW = 19;
   localparam int unsigned DistW   = 21;
   localparam int unsigned Dist2W  = 42;
   localparam int unsigned RootW   = 21;
   localparam int unsigned GapW    = 20;
   localparam int unsigned PlaneW  = 64;
   localparam int unsigned PSumW   = 40;
   localparam int unsigned NPlanes = 4;

   localparam logic [GapW-1:0] GapMax = '1;

   typedef enum logic [2:0] {
      REASON_NONE   = 3'd0,
      REASON_FAR    = 3'd1,
      REASON_NEAR   = 3'd2,
      REASON_LEFT   = 3'd3,
      REASON_RIGHT  = 3'd4,
      REASON_BOTTOM = 3'd5,
      REASON_TOP    = 3'd6
   } reason_type;

   typedef enum logic [2:0] {
      CSR_LEFT   = 3'd0,
      CSR_RIGHT  = 3'd1,
      CSR_BOTTOM = 3'd2,
      CSR_TOP    = 3'd3,
      CSR_EYE    = 3'd4,
      CSR_NEAR   = 3'd5,
      CSR_FAR    = 3'd6,
      CSR_NONE   = 3'd7
   } csr_index_type;

   localparam logic [GapW-1:0] FarReset = 20'd48000;

   // carried alongside the root through the sqrt pipe
   typedef struct packed {
      reason_type         reason;
      logic [DistW-1:0]   nr;
   } side_type;

endpackage

[hdl/sfc_req_if.sv]
interface sfc_req_if import sfc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [CoordW-1:0]  center_x;
   logic signed [CoordW-1:0]  center_y;
   logic signed [CoordW-1:0]  center_z;
   logic [RadiusW-1:0]        sphere_radius;

   modport source (output valid, center_x, center_y, center_z, sphere_radius, input ready);
   modport sink   (input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

[hdl/sfc_rsp_if.sv]
interface sfc_rsp_if import sfc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             visible;
   logic [2:0]       cull_reason;
   logic [GapW-1:0]  near_gap;

   modport source (output valid, visible, cull_reason, near_gap, input ready);
   modport sink   (input valid, visible, cull_reason, near_gap, output ready);
endinterface

[hdl/sphere_frustum_cull.sv]
// channel | dir | handshake         | payload
// req     | in  | valid/ready       | center_x, center_y, center_z, sphere_radius
// rsp     | out | valid/ready       | visible, cull_reason, near_gap
// csr     | in  | csr_we (no wait)  | csr_index, csr_wdata
//
// One request per cycle unless a waiting result holds the pipe; 25 register stages: three
// arithmetic stages, 21 sqrt stages (one root bit each) and the output register.
// Synchronous active-high reset clears valid bits and loads register defaults.
// When a result waits on rsp the whole pipe holds; ready follows the output stage.
module sphere_frustum_cull import sfc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   sfc_req_if.sink           req_chan,
   sfc_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [PlaneW-1:0] csr_wdata
);

   logic [PlaneW-1:0]    plane_ff [0:NPlanes-1];
   logic [3*CoordW-1:0]  eye_ff;
   logic [GapW-1:0]      near_ff;
   logic [GapW-1:0]      far_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NPlanes; p++) plane_ff[p] <= '0;
         eye_ff  <= '0;
         near_ff <= '0;
         far_ff  <= FarReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEFT:   plane_ff[0] <= csr_wdata;
            CSR_RIGHT:  plane_ff[1] <= csr_wdata;
            CSR_BOTTOM: plane_ff[2] <= csr_wdata;
            CSR_TOP:    plane_ff[3] <= csr_wdata;
            CSR_EYE:    eye_ff      <= csr_wdata[3*CoordW-1:0];
            CSR_NEAR:   near_ff     <= csr_wdata[GapW-1:0];
            CSR_FAR:    far_ff      <= csr_wdata[GapW-1:0];
            default:    ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 1: deltas and limits
   logic                      s1_valid_ff;
   logic signed [DistW-1:0]   dx_ff, dy_ff, dz_ff;
   logic [DistW-1:0]          fr_ff, nr_ff;
   logic signed [CoordW-1:0]  x_ff, y_ff, z_ff;
   logic [RadiusW-1:0]        r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (adv) begin
         dx_ff <= {req_chan.center_x[CoordW-1], req_chan.center_x}
                - {eye_ff[CoordW-1], eye_ff[CoordW-1:0]};
         dy_ff <= {req_chan.center_y[CoordW-1], req_chan.center_y}
                - {eye_ff[2*CoordW-1], eye_ff[2*CoordW-1:CoordW]};
         dz_ff <= {req_chan.center_z[CoordW-1], req_chan.center_z}
                - {eye_ff[3*CoordW-1], eye_ff[3*CoordW-1:2*CoordW]};
         fr_ff <= {1'b0, far_ff} + {2'b0, req_chan.sphere_radius};
         nr_ff <= {1'b0, near_ff} + {2'b0, req_chan.sphere_radius};
         x_ff  <= req_chan.center_x;
         y_ff  <= req_chan.center_y;
         z_ff  <= req_chan.center_z;
         r_ff  <= req_chan.sphere_radius;
      end
   end

   // stage 2: products
   logic                      s2_valid_ff;
   logic [Dist2W-1:0]         sqx_ff, sqy_ff, sqz_ff, fr2_ff, nr2_ff;
   logic [DistW-1:0]          s2_nr_ff;
   logic signed [PSumW-1:0]   pa_ff [0:NPlanes-1];
   logic signed [PSumW-1:0]   pb_ff [0:NPlanes-1];
   logic signed [PSumW-1:0]   pc_ff [0:NPlanes-1];
   logic signed [PSumW-1:0]   pk_ff [0:NPlanes-1];

   function automatic logic signed [PSumW-1:0] mul_nc(logic [15:0] n, logic [CoordW-1:0] v);
      logic signed [35:0] prod;
      prod = $signed({{20{n[15]}}, n}) * $signed({{16{v[CoordW-1]}}, v});
      return {{(PSumW-36){prod[35]}}, prod};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         sqx_ff <= $signed({{DistW{dx_ff[DistW-1]}}, dx_ff})
                 * $signed({{DistW{dx_ff[DistW-1]}}, dx_ff});
         sqy_ff <= $signed({{DistW{dy_ff[DistW-1]}}, dy_ff})
                 * $signed({{DistW{dy_ff[DistW-1]}}, dy_ff});
         sqz_ff <= $signed({{DistW{dz_ff[DistW-1]}}, dz_ff})
                 * $signed({{DistW{dz_ff[DistW-1]}}, dz_ff});
         fr2_ff <= {{DistW{1'b0}}, fr_ff} * {{DistW{1'b0}}, fr_ff};
         nr2_ff <= {{DistW{1'b0}}, nr_ff} * {{DistW{1'b0}}, nr_ff};
         s2_nr_ff <= nr_ff;
         for (int p = 0; p < NPlanes; p++) begin
            pa_ff[p] <= mul_nc(plane_ff[p][15:0], x_ff);
            pb_ff[p] <= mul_nc(plane_ff[p][31:16], y_ff);
            pc_ff[p] <= mul_nc(plane_ff[p][47:32], z_ff);
            pk_ff[p] <= {{(PSumW-34){plane_ff[p][63]}}, plane_ff[p][63:48], 18'b0}
                      + {{(PSumW-33){1'b0}}, r_ff, 14'b0};
         end
      end
   end

   // stage 3: sums, tests, first failing test
   logic                     s3_valid_ff;
   logic [Dist2W-1:0]        dist2_ff;
   side_type                 s3_side_ff;
   logic [Dist2W-1:0]        dist2_in;
   logic [NPlanes-1:0]       out_in;
   reason_type               reason_in;
   logic signed [PSumW-1:0]  psum;

   always_comb begin
      dist2_in = sqx_ff + sqy_ff + sqz_ff;
      out_in   = '0;
      for (int p = 0; p < NPlanes; p++) begin
         psum      = pa_ff[p] + pb_ff[p] + pc_ff[p] + pk_ff[p];
         out_in[p] = psum[PSumW-1] || (psum == '0);
      end
      if (dist2_in > fr2_ff)      reason_in = REASON_FAR;
      else if (dist2_in < nr2_ff) reason_in = REASON_NEAR;
      else if (out_in[0])         reason_in = REASON_LEFT;
      else if (out_in[1])         reason_in = REASON_RIGHT;
      else if (out_in[2])         reason_in = REASON_BOTTOM;
      else if (out_in[3])         reason_in = REASON_TOP;
      else                        reason_in = REASON_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         dist2_ff          <= dist2_in;
         s3_side_ff.reason <= reason_in;
         s3_side_ff.nr     <= s2_nr_ff;
      end
   end

   logic              sq_valid;
   logic [RootW-1:0]  sq_root;
   side_type          sq_side;

   sfc_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s3_valid_ff),
      .in_dist2  (dist2_ff),
      .in_side   (s3_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // output register
   logic [GapW-1:0]  gap_in;
   logic [RootW-1:0] diff;
   logic             vis_ff;
   reason_type       reason_ff;
   logic [GapW-1:0]  gap_ff;

   always_comb begin
      diff = (sq_root >= sq_side.nr) ? sq_root - sq_side.nr : '0;
      if (sq_side.reason != REASON_NONE) gap_in = '0;
      else if (diff[RootW-1])            gap_in = GapMax;
      else                               gap_in = diff[GapW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sq_valid;
      end
      if (adv) begin
         vis_ff    <= (sq_side.reason == REASON_NONE);
         reason_ff <= sq_side.reason;
         gap_ff    <= gap_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.visible     = vis_ff;
   assign rsp_chan.cull_reason = reason_ff;
   assign rsp_chan.near_gap    = gap_ff;

   a_vis_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (vis_ff == (reason_ff == REASON_NONE)))
      else $error("visible disagrees with cull reason");

   a_culled_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !vis_ff) |-> (gap_ff == '0))
      else $error("culled sphere with nonzero gap");

   a_reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (reason_ff <= REASON_TOP))
      else $error("cull reason out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(s3_valid_ff) && $stable(dist2_ff)))
      else $error("pipe moved during stall");

endmodule

[hdl/sfc_isqrt.sv]
module sfc_isqrt import sfc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [Dist2W-1:0]  in_dist2,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [RootW-1:0]   out_root,
   output side_type           out_side
);

   // one root bit per stage, MSB first
   logic [Dist2W-1:0]  rem_ff   [0:RootW-1];
   logic [RootW-1:0]   root_ff  [0:RootW-1];
   side_type           side_ff  [0:RootW-1];
   logic               valid_ff [0:RootW-1];

   for (genvar k = 0; k < RootW; k++) begin : g_stage
      localparam int unsigned Bit = RootW - 1 - k;
      logic [Dist2W-1:0]  rem_prev;
      logic [RootW-1:0]   root_prev;
      side_type           side_prev;
      logic               valid_prev;
      logic [Dist2W:0]    trial;
      logic [Dist2W-1:0]  rem_in;
      logic [RootW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign rem_prev   = in_dist2;
         assign root_prev  = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         trial = ({{(Dist2W+1-RootW){1'b0}}, root_prev} << (Bit + 1))
               | ((Dist2W+1)'(1) << (2 * Bit));
         if ({1'b0, rem_prev} >= trial) begin
            rem_in  = rem_prev - trial[Dist2W-1:0];
            root_in = root_prev | (RootW'(1) << Bit);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[RootW-1];
   assign out_root  = root_ff[RootW-1];
   assign out_side  = side_ff[RootW-1];

endmodule
